@@ hdl/lfu_pkg.sv @@
// Shared types and constants for the LFU cache unit.
// No dependencies; imported by lfu_cache_unit.
package lfu_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int USE_W           = 32;
    localparam int CAP_W           = 5;
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int CAP_RESET       = 16;

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    // Saturating increment of a use count.
    function automatic logic [USE_W-1:0] sat_inc(input logic [USE_W-1:0] c);
        sat_inc = (&c) ? c : c + USE_W'(1);
    endfunction

endpackage

@@ hdl/lfu_entry_ram.sv @@
// Synchronous entry memory with one read and one write port; read data is registered.
// Depends on nothing outside this file.
module lfu_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 100
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lfu_cache_unit.sv @@
// LFU cache unit: fully associative key/value store, least-frequently-used
// replacement with least-recently-used tie break. Depends on lfu_pkg and
// lfu_entry_ram.
//
// A put goes through an accept step, a scan pass over every entry that finds
// the key, the victim and the first free slot, a decision step, and a
// read-modify-write pass that updates recency ranks and the touched or new
// entry, before s_tready is high again. A get hit then also loads the output
// register; a get miss, and a put while the capacity is zero, skip the second
// pass. The entry memory is read one entry a cycle in both passes. Results of
// gets sit in an output register, so a new item is taken while one still
// waits; a later get whose result is ready stalls until the waiting result has
// been taken.
// There is no clearing pass after reset: valid bits live in flip-flops.
module lfu_cache_unit #(
    parameter int MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_wr_data,   // capacity
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,       // lookup_key, store_value
    input  logic                       s_tuser,       // kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,       // read_value
    output logic                       m_tuser        // hit
);
    import lfu_pkg::*;

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW    = $clog2(MAX_ENTRIES + 1);
    localparam int OW    = (NW > CAP_W) ? NW : CAP_W;
    localparam int WORD_W = KEY_W + VAL_W + USE_W + IW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPD, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [NW-1:0] occ_reg;

    logic kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    logic [NW-1:0] cnt_reg;
    logic proc_reg;
    logic [IW-1:0] proc_idx_reg;

    logic found_reg, free_found_reg, vfound_reg;
    logic [IW-1:0] e_idx_reg, free_idx_reg, v_idx_reg;
    logic [IW-1:0] e_rank_reg, v_rank_reg;
    logic [USE_W-1:0] v_cnt_reg;
    logic [VAL_W-1:0] e_val_reg;

    logic insert_reg, evict_reg;
    logic [IW-1:0] tgt_reg;

    logic m_tvalid_reg, m_hit_reg;
    logic [VAL_W-1:0] m_data_reg;

    // Memory port
    logic rd_en;
    logic [WORD_W-1:0] rd_data, wr_data;
    logic wr_en;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [USE_W-1:0] rd_cnt;
    logic [IW-1:0] rd_rank;

    assign {rd_key, rd_val, rd_cnt, rd_rank} = rd_data;

    logic issue;
    assign issue = (state_reg == ST_SCAN || state_reg == ST_UPD)
                   && (cnt_reg != NW'(MAX_ENTRIES));
    assign rd_en = issue;

    lfu_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (proc_idx_reg),
        .wr_data (wr_data)
    );

    // Capacity clamp and full check
    logic [OW-1:0] cap_ext, cap_eff;
    logic full;
    always_comb begin
        cap_ext = OW'(capacity_reg);
        cap_eff = (cap_ext > OW'(MAX_ENTRIES)) ? OW'(MAX_ENTRIES) : cap_ext;
        full    = OW'(occ_reg) >= cap_eff;
    end

    // Second-pass write data for the entry coming back from memory.
    logic proc_valid;
    assign proc_valid = valid_reg[proc_idx_reg];
    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_data;
        if (state_reg == ST_UPD && proc_reg) begin
            if (proc_idx_reg == tgt_reg) begin
                wr_en = 1'b1;
                if (insert_reg) begin
                    wr_data = {key_reg, val_reg, USE_W'(1), IW'(0)};
                end else begin
                    wr_data = {rd_key, (kind_reg == KIND_PUT) ? val_reg : rd_val,
                               sat_inc(rd_cnt), IW'(0)};
                end
            end else if (proc_valid) begin
                wr_en = 1'b1;
                if (insert_reg) begin
                    wr_data = {rd_key, rd_val, rd_cnt,
                               rd_rank + IW'(1)
                               - IW'(evict_reg && (rd_rank > v_rank_reg))};
                end else begin
                    wr_data = {rd_key, rd_val, rd_cnt,
                               rd_rank + IW'(rd_rank < e_rank_reg)};
                end
            end
        end
    end

    logic scan_hit, scan_better;
    always_comb begin
        scan_hit    = proc_valid && (rd_key == key_reg);
        scan_better = !vfound_reg || (rd_cnt < v_cnt_reg)
                      || ((rd_cnt == v_cnt_reg) && (rd_rank > v_rank_reg));
    end

    logic [IW-1:0] ins_slot;
    always_comb begin
        if (full && (!free_found_reg || v_idx_reg < free_idx_reg)) begin
            ins_slot = v_idx_reg;
        end else begin
            ins_slot = free_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_W'(CAP_RESET);
            valid_reg    <= '0;
            occ_reg      <= '0;
            proc_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            proc_reg     <= issue;
            proc_idx_reg <= cnt_reg[IW-1:0];
            if (issue) begin
                cnt_reg <= cnt_reg + NW'(1);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg       <= s_tuser;
                        key_reg        <= s_tdata[31:0];
                        val_reg        <= s_tdata[63:32];
                        cnt_reg        <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        vfound_reg     <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (proc_reg) begin
                        if (scan_hit && !found_reg) begin
                            found_reg  <= 1'b1;
                            e_idx_reg  <= proc_idx_reg;
                            e_rank_reg <= rd_rank;
                            e_val_reg  <= rd_val;
                        end
                        if (proc_valid && scan_better) begin
                            vfound_reg <= 1'b1;
                            v_idx_reg  <= proc_idx_reg;
                            v_cnt_reg  <= rd_cnt;
                            v_rank_reg <= rd_rank;
                        end
                        if (!proc_valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= proc_idx_reg;
                        end
                    end else if (!issue) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    cnt_reg <= '0;
                    if (kind_reg == KIND_GET) begin
                        insert_reg <= 1'b0;
                        tgt_reg    <= e_idx_reg;
                        state_reg  <= found_reg ? ST_UPD : ST_OUT;
                    end else if (cap_eff == '0) begin
                        state_reg <= ST_IDLE;
                    end else if (found_reg) begin
                        insert_reg <= 1'b0;
                        tgt_reg    <= e_idx_reg;
                        state_reg  <= ST_UPD;
                    end else begin
                        insert_reg <= 1'b1;
                        evict_reg  <= full;
                        tgt_reg    <= ins_slot;
                        if (full) begin
                            valid_reg[v_idx_reg] <= 1'b0;
                        end
                        valid_reg[ins_slot] <= 1'b1;
                        occ_reg   <= occ_reg + NW'(1) - NW'(full);
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (!proc_reg && !issue) begin
                        state_reg <= (kind_reg == KIND_GET) ? ST_OUT : ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_hit_reg    <= found_reg;
                        m_data_reg   <= found_reg ? e_val_reg : '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    a_occ_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (occ_reg == NW'($countones(valid_reg))))
        else $error("occupancy differs from number of valid entries");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= NW'(MAX_ENTRIES))
        else $error("occupancy above entry count");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result carries nonzero data");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPD) |-> !wr_en)
        else $error("entry memory written outside update pass");

endmodule
